// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Condition holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the serial frame slave.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // CRC-16, polynomial 0x1021, no reflection, no final xor
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // Frame layout
    localparam int          MIN_FRAME  = 8;
    localparam int          TRAILER    = 3;
    localparam logic [7:0]  REPLY_LEN_BYTE = 8'd3;

    // Input kind codes
    localparam logic [1:0]  CMD_BYTE     = 2'd0;
    localparam logic [1:0]  CMD_RX_ERROR = 2'd1;
    localparam logic [1:0]  CMD_TX_DONE  = 2'd2;

    // Register indexes of the configuration channel
    localparam logic [2:0]  CFG_SLAVE_ADDRESS = 3'd0;
    localparam logic [2:0]  CFG_HEADER_FIRST  = 3'd1;
    localparam logic [2:0]  CFG_HEADER_SECOND = 3'd2;
    localparam logic [2:0]  CFG_TAIL_BYTE     = 3'd3;
    localparam logic [2:0]  CFG_READ_CODE     = 3'd4;

    // Request to the bit-serial CRC unit
    typedef struct packed {
        logic       start;
        logic       init;
        logic [7:0] data;
    } crc_ctl_t;

    // Status of the bit-serial CRC unit
    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } crc_sts_t;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RXCRC = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_LIGHT = 6'b001000,
        ST_REPLY = 6'b010000,
        ST_RWAIT = 6'b100000
    } state_t;

endpackage

// File: hw/rtl/sfs_crc_unit.sv
// ----------------------------------------------------------------------------
// sfs_crc_unit
// Bit-serial CRC-16 engine: folds one byte at a time, MSB first.
// ----------------------------------------------------------------------------
module sfs_crc_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  sfs_pkg::crc_ctl_t ctl,
    output sfs_pkg::crc_sts_t sts
);

    logic        busy_reg,  busy_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] crc_reg,   crc_next;
    logic        fb;

    // Step one bit per cycle while busy; load a new byte on start
    always_comb
    begin
        busy_next    = busy_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        crc_next     = crc_reg;
        fb           = crc_reg[15] ^ shift_reg[7];
        if (busy_reg)
        begin
            crc_next     = {crc_reg[14:0], 1'b0} ^ (fb ? sfs_pkg::CRC_POLY : 16'h0000);
            shift_next   = {shift_reg[6:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 3'd1;
            if (bit_cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
        else if (ctl.start)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = 3'd0;
            shift_next   = ctl.data;
            if (ctl.init)
            begin
                crc_next = sfs_pkg::CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            bit_cnt_reg <= 3'd0;
            crc_reg     <= sfs_pkg::CRC_INIT;
        end
        else
        begin
            busy_reg    <= busy_next;
            bit_cnt_reg <= bit_cnt_next;
            crc_reg     <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign sts.busy = busy_reg;
    assign sts.crc  = crc_reg;

endmodule

// File: hw/rtl/serial_frame_slave_crc16.sv
// ----------------------------------------------------------------------------
// serial_frame_slave_crc16
// Framed serial slave: collects bytes, checks header, CRC-16 and address,
// answers read requests with a sensor reply frame, forwards other codes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per item: tuser is the kind (byte received,
//   receive error, transmission complete), tdata the byte and sensor levels.
//   m_axis gives reply frame bytes (tuser 0, tlast on the eleventh byte) or
//   one light-controller command (tuser 1).
//   cfg writes the five 8-bit registers at any time; it is always ready.
// Sequencing:
//   Control items and the first three bytes of a frame are taken in idle.
//   Every later byte waits while the single bit-serial CRC unit folds the
//   byte leaving the three-byte trailer window, one bit per cycle.
//   A frame end adds a check state, then a light state for a light command
//   or reply states for a reply frame, which reuses the same unit.
//   s_axis is not ready while an item or a reply is in progress.
// Reset clears the byte count, the busy flag of the transmitter and the valid
// flag of the output register, and loads the register defaults. When m_axis stalls,
// the pending result holds and the sequencer waits for the output slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_frame_slave_crc16
#(
    parameter int BUFFER_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] rx_byte, [17:8] sensor_levels, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [15:8] light_command
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] result_kind

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    // Configuration registers
    logic [7:0] slave_address_reg, header_first_reg, header_second_reg;
    logic [7:0] tail_byte_reg, read_code_reg;

    // Frame tracking
    sfs_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             tx_busy_reg, tx_busy_next;
    logic             tail_hit_reg, tail_hit_next;
    logic [3:0]       reply_idx_reg, reply_idx_next;
    logic [7:0]       hdr0_reg, hdr0_next, hdr1_reg, hdr1_next;
    logic [7:0]       addr_reg, addr_next, func_reg, func_next;
    logic [7:0]       win0_reg, win0_next, win1_reg, win1_next, win2_reg, win2_next;
    logic             level_reg, level_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic [7:0]  out_light_reg, out_light_next;

    // Decoded input item
    logic [1:0]       in_cmd;
    logic [7:0]       in_byte;
    logic [9:0]       in_levels;
    logic             in_acc;
    logic             out_free;
    logic [CNT_W-1:0] new_count;
    logic             frame_ok;
    logic [7:0]       reply_byte;

    sfs_pkg::crc_ctl_t crc_ctl;
    sfs_pkg::crc_sts_t crc_sts;

    sfs_crc_unit u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .sts   (crc_sts)
    );

    assign in_cmd    = s_axis_tuser;
    assign in_byte   = s_axis_tdata[7:0];
    assign in_levels = s_axis_tdata[17:8];
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign new_count = count_reg + CNT_W'(1);

    // Header, CRC and address check of a finished frame
    assign frame_ok = (hdr0_reg == header_first_reg) && (hdr1_reg == header_second_reg)
                   && ({win0_reg, win1_reg} == crc_sts.crc)
                   && (addr_reg == slave_address_reg);

    // Select the reply frame byte
    always_comb
    begin
        unique case (reply_idx_reg)
            4'd0:    reply_byte = header_first_reg;
            4'd1:    reply_byte = header_second_reg;
            4'd2:    reply_byte = slave_address_reg;
            4'd3:    reply_byte = read_code_reg;
            4'd4:    reply_byte = sfs_pkg::REPLY_LEN_BYTE;
            4'd5,
            4'd6,
            4'd7:    reply_byte = {7'd0, level_reg};
            4'd8:    reply_byte = crc_sts.crc[15:8];
            4'd9:    reply_byte = crc_sts.crc[7:0];
            default: reply_byte = tail_byte_reg;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        tx_busy_next   = tx_busy_reg;
        tail_hit_next  = tail_hit_reg;
        reply_idx_next = reply_idx_reg;
        hdr0_next      = hdr0_reg;
        hdr1_next      = hdr1_reg;
        addr_next      = addr_reg;
        func_next      = func_reg;
        win0_next      = win0_reg;
        win1_next      = win1_reg;
        win2_next      = win2_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_light_next = out_light_reg;
        crc_ctl.start  = 1'b0;
        crc_ctl.init   = 1'b0;
        crc_ctl.data   = win0_reg;
        s_axis_tready  = 1'b0;

        unique case (state_reg)
            sfs_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_acc)
                begin
                    if (in_cmd == sfs_pkg::CMD_RX_ERROR)
                    begin
                        count_next = '0;
                    end
                    else if (in_cmd == sfs_pkg::CMD_TX_DONE)
                    begin
                        tx_busy_next = 1'b0;
                    end
                    else if (in_cmd == sfs_pkg::CMD_BYTE)
                    begin
                        // Capture the fixed frame fields as they arrive
                        if (count_reg == CNT_W'(0)) hdr0_next = in_byte;
                        if (count_reg == CNT_W'(1)) hdr1_next = in_byte;
                        if (count_reg == CNT_W'(2)) addr_next = in_byte;
                        if (count_reg == CNT_W'(3)) func_next = in_byte;
                        // Advance the trailer window
                        win0_next  = win1_reg;
                        win1_next  = win2_reg;
                        win2_next  = in_byte;
                        level_next = &in_levels;
                        tail_hit_next = (in_byte == tail_byte_reg)
                                     && (new_count >= CNT_W'(sfs_pkg::MIN_FRAME));
                        // Drop the count at a frame end or a full buffer
                        if (tail_hit_next || (new_count >= CNT_W'(BUFFER_BYTES)))
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = new_count;
                        end
                        // Fold the byte that leaves the window into the CRC
                        if (count_reg >= CNT_W'(sfs_pkg::TRAILER))
                        begin
                            crc_ctl.start = 1'b1;
                            crc_ctl.init  = (count_reg == CNT_W'(sfs_pkg::TRAILER));
                            state_next    = sfs_pkg::ST_RXCRC;
                        end
                    end
                end
            end

            sfs_pkg::ST_RXCRC:
            begin
                if (!crc_sts.busy)
                begin
                    state_next = tail_hit_reg ? sfs_pkg::ST_CHECK : sfs_pkg::ST_IDLE;
                end
            end

            sfs_pkg::ST_CHECK:
            begin
                priority if (!frame_ok)
                begin
                    state_next = sfs_pkg::ST_IDLE;
                end
                else if (func_reg != read_code_reg)
                begin
                    state_next = sfs_pkg::ST_LIGHT;
                end
                else if (tx_busy_reg)
                begin
                    state_next = sfs_pkg::ST_IDLE;
                end
                else
                begin
                    tx_busy_next   = 1'b1;
                    reply_idx_next = 4'd0;
                    state_next     = sfs_pkg::ST_REPLY;
                end
            end

            sfs_pkg::ST_LIGHT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b1;
                    out_byte_next  = 8'd0;
                    out_last_next  = 1'b0;
                    out_light_next = func_reg;
                    state_next     = sfs_pkg::ST_IDLE;
                end
            end

            sfs_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b0;
                    out_byte_next  = reply_byte;
                    out_last_next  = (reply_idx_reg == 4'd10);
                    out_light_next = 8'd0;
                    if (reply_idx_reg < 4'd8)
                    begin
                        // First eight bytes also feed the reply CRC
                        crc_ctl.start = 1'b1;
                        crc_ctl.init  = (reply_idx_reg == 4'd0);
                        crc_ctl.data  = reply_byte;
                        state_next    = sfs_pkg::ST_RWAIT;
                    end
                    else if (reply_idx_reg == 4'd10)
                    begin
                        state_next = sfs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        reply_idx_next = reply_idx_reg + 4'd1;
                    end
                end
            end

            sfs_pkg::ST_RWAIT:
            begin
                if (!crc_sts.busy)
                begin
                    reply_idx_next = reply_idx_reg + 4'd1;
                    state_next     = sfs_pkg::ST_REPLY;
                end
            end

            default:
            begin
                state_next = sfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfs_pkg::ST_IDLE;
            count_reg     <= '0;
            tx_busy_reg   <= 1'b0;
            tail_hit_reg  <= 1'b0;
            reply_idx_reg <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tx_busy_reg   <= tx_busy_next;
            tail_hit_reg  <= tail_hit_next;
            reply_idx_reg <= reply_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        hdr0_reg      <= hdr0_next;
        hdr1_reg      <= hdr1_next;
        addr_reg      <= addr_next;
        func_reg      <= func_next;
        win0_reg      <= win0_next;
        win1_reg      <= win1_next;
        win2_reg      <= win2_next;
        level_reg     <= level_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_light_reg <= out_light_next;
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'd1;
            header_first_reg  <= 8'd170;
            header_second_reg <= 8'd85;
            tail_byte_reg     <= 8'd13;
            read_code_reg     <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfs_pkg::CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_data;
                sfs_pkg::CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                sfs_pkg::CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                sfs_pkg::CFG_TAIL_BYTE:     tail_byte_reg     <= cfg_data;
                sfs_pkg::CFG_READ_CODE:     read_code_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_light_reg, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_kind_reg;

    // Input is only taken while the CRC unit is free
    `ASSERT_IMPLIES(a_ready_crc_idle, clk, rst_n, s_axis_tready, !crc_sts.busy)
    // Count never reaches the buffer size
    `ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_reg < CNT_W'(BUFFER_BYTES))
    // Reply CRC wait only for the first eight reply bytes
    `ASSERT_IMPLIES(a_rwait_idx, clk, rst_n, state_reg == sfs_pkg::ST_RWAIT,
        reply_idx_reg < 4'd8)
    // A checked frame always leaves the check state at once
    `ASSERT_NEXT(a_check_once, clk, rst_n, state_reg == sfs_pkg::ST_CHECK,
        state_reg != sfs_pkg::ST_CHECK)

endmodule

// File: bench/tb_serial_frame_slave_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_slave_crc16
// Self-checking bench for the framed serial slave with CRC-16 check.
// Builds byte streams of valid and damaged frames, receive errors, overflow
// runs and transmit-done events, predicts every reply byte and light command
// from its own model of the frame buffer and registers, and checks the
// output stream in order under random gaps, stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_serial_frame_slave_crc16;

    localparam int          BUFFER_BYTES = 32;
    localparam int          CLK_HALF     = 10;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE       = 200;
    localparam int          HOLD_CYCLES  = 500;
    localparam int          PHASE_ITEMS  = 82;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic        KIND_REPLY   = 1'b0;
    localparam logic        KIND_LIGHT   = 1'b1;
    localparam logic [9:0]  ALL_LEVELS   = 10'h3FF;

    typedef enum int {FLAW_NONE, FLAW_HDR1, FLAW_HDR2, FLAW_CRC, FLAW_ADDR} flaw_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic [9:0] levels;
    } rx_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [7:0] light;
    } slave_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [7:0] rx_byte, [17:8] sensor_levels, rest zero
    logic [1:0]  s_axis_tuser = '0;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] tx_byte, [15:8] light_command
    logic        m_axis_tlast;
    logic        m_axis_tuser;        // [0] result_kind
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // Model registers and state
    logic [7:0]  m_addr = 8'd1;
    logic [7:0]  m_hdr1 = 8'd170;
    logic [7:0]  m_hdr2 = 8'd85;
    logic [7:0]  m_tail = 8'd13;
    logic [7:0]  m_read = 8'd1;
    logic [7:0]  rx_buf [BUFFER_BYTES];
    int          fill_level = 0;
    logic        reply_pending = 1'b0;

    rx_item_t      item_q [$];
    slave_result_t expected_q [$];
    rx_item_t      drv_item;

    int n_pushed = 0;
    int n_made = 0;
    int n_accepted = 0;
    int n_frames = 0;
    int n_reply_bytes = 0;
    int n_lights = 0;
    int n_settings = 0;
    int results_seen = 0;
    int fail_count = 0;
    int cycle_count = 0;

    serial_frame_slave_crc16 uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Fold one byte into a CRC-16 (MSB first)
    function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            r = r[15] ? ((r << 1) ^ sfs_pkg::CRC_POLY) : (r << 1);
        return r;
    endfunction

    // Check a closed frame and queue the replies or light command it causes
    function automatic void close_frame(int len, logic [9:0] levels);
        logic [15:0] sum;
        logic [15:0] carried;
        logic [7:0]  reply [11];
        logic [7:0]  d;
        slave_result_t r;
        sum = sfs_pkg::CRC_INIT;
        for (int i = 0; i < len - sfs_pkg::TRAILER; i++)
            sum = crc16_byte(sum, rx_buf[i]);
        carried = {rx_buf[len - 3], rx_buf[len - 2]};
        if (rx_buf[0] != m_hdr1 || rx_buf[1] != m_hdr2 || carried != sum
            || rx_buf[2] != m_addr)
            return;
        if (rx_buf[3] != m_read)
        begin
            r = '{kind: KIND_LIGHT, tx_byte: 8'h00, last: 1'b0, light: rx_buf[3]};
            expected_q.push_back(r);
            return;
        end
        // Drop a read request until a transmit-done event clears the pending reply
        if (reply_pending)
            return;
        reply_pending = 1'b1;
        d = (levels == ALL_LEVELS) ? 8'd1 : 8'd0;
        reply[0] = m_hdr1;
        reply[1] = m_hdr2;
        reply[2] = m_addr;
        reply[3] = m_read;
        reply[4] = sfs_pkg::REPLY_LEN_BYTE;
        reply[5] = d;
        reply[6] = d;
        reply[7] = d;
        sum = sfs_pkg::CRC_INIT;
        for (int i = 0; i < 8; i++)
            sum = crc16_byte(sum, reply[i]);
        reply[8]  = sum[15:8];
        reply[9]  = sum[7:0];
        reply[10] = m_tail;
        for (int k = 0; k < 11; k++)
        begin
            r = '{kind: KIND_REPLY, tx_byte: reply[k], last: (k == 10), light: 8'h00};
            expected_q.push_back(r);
        end
    endfunction

    // Advance the model by one accepted item
    function automatic void predict_item(rx_item_t it);
        case (it.cmd)
            sfs_pkg::CMD_RX_ERROR: fill_level = 0;
            sfs_pkg::CMD_TX_DONE:  reply_pending = 1'b0;
            sfs_pkg::CMD_BYTE:
            begin
                if (fill_level >= BUFFER_BYTES)
                    fill_level = 0;
                rx_buf[fill_level] = it.data;
                fill_level++;
                if (it.data == m_tail && fill_level >= sfs_pkg::MIN_FRAME)
                begin
                    close_frame(fill_level, it.levels);
                    fill_level = 0;
                end
                else if (fill_level >= BUFFER_BYTES)
                    fill_level = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic void add_item(logic [1:0] cmd, logic [7:0] data, logic [9:0] levels);
        rx_item_t it;
        it.cmd    = cmd;
        it.data   = data;
        it.levels = levels;
        item_q.push_back(it);
        n_pushed++;
        if (cmd != CMD_UNUSED)
            n_made++;
    endfunction

    // Sensor levels carried with a frame's tail: often all high, sometimes one low, else random
    function automatic logic [9:0] tail_levels();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return ALL_LEVELS;
        if (pick < 5)
            return ALL_LEVELS ^ (10'h1 << $urandom_range(9));
        return 10'($urandom_range(1023));
    endfunction

    // Queue the bytes of one frame, optionally damaged
    function automatic void add_frame(logic [7:0] func, int body_len, flaw_t flaw,
                                      logic [9:0] levels, logic [7:0] body_fill);
        logic [7:0]  fb [BUFFER_BYTES];
        logic [15:0] sum;
        logic [7:0]  b;
        int          len;
        len = 4 + body_len + sfs_pkg::TRAILER;
        fb[0] = m_hdr1;
        fb[1] = m_hdr2;
        fb[2] = m_addr;
        fb[3] = func;
        if (flaw == FLAW_HDR1)
            fb[0] = m_hdr1 ^ (8'h1 << $urandom_range(7));
        if (flaw == FLAW_HDR2)
            fb[1] = m_hdr2 ^ (8'h1 << $urandom_range(7));
        if (flaw == FLAW_ADDR)
            fb[2] = m_addr ^ (8'h1 << $urandom_range(7));
        // Keep the body clear of the tail value so the frame ends where intended
        for (int i = 0; i < body_len; i++)
        begin
            b = (i == 0 && body_fill != 8'h00) ? body_fill : 8'($urandom_range(255));
            if (b == m_tail)
                b ^= 8'h80;
            fb[4 + i] = b;
        end
        sum = sfs_pkg::CRC_INIT;
        for (int i = 0; i < len - sfs_pkg::TRAILER; i++)
            sum = crc16_byte(sum, fb[i]);
        fb[len - 3] = sum[15:8];
        fb[len - 2] = sum[7:0];
        if (flaw == FLAW_CRC)
            fb[len - 2] ^= 8'h1 << $urandom_range(7);
        fb[len - 1] = m_tail;
        for (int i = 0; i < len - 1; i++)
            add_item(sfs_pkg::CMD_BYTE, fb[i], 10'($urandom_range(1023)));
        add_item(sfs_pkg::CMD_BYTE, fb[len - 1], levels);
        n_frames++;
    endfunction

    function automatic logic [7:0] pick_func();
        logic [7:0] f;
        if ($urandom_range(1) == 0)
            return m_read;
        f = 8'($urandom_range(255));
        return (f == m_read) ? f + 8'd1 : f;
    endfunction

    function automatic logic [7:0] non_tail_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == m_tail) ? ~b : b;
    endfunction

    // Queue a mix of well-formed, damaged and partial frames, overflow runs and control items
    function automatic void add_random_phase(int target);
        int stop_at;
        int pick;
        int n;
        stop_at = n_made + target;
        while (n_made < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                add_frame(pick_func(), $urandom_range(1, 4), FLAW_NONE, tail_levels(), 8'h00);
            else if (pick < 62)
                add_item(sfs_pkg::CMD_TX_DONE, 8'($urandom_range(255)),
                         10'($urandom_range(1023)));
            else if (pick < 72)
                add_frame(pick_func(), $urandom_range(1, 4),
                          flaw_t'($urandom_range(FLAW_HDR1, FLAW_ADDR)), tail_levels(), 8'h00);
            else if (pick < 84)
            begin
                // Partial frame or noise, then discard it with a receive error
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    add_item(sfs_pkg::CMD_BYTE, (i == 0) ? m_hdr1 : 8'($urandom_range(255)),
                             10'($urandom_range(1023)));
                add_item(sfs_pkg::CMD_RX_ERROR, 8'($urandom_range(255)),
                         10'($urandom_range(1023)));
            end
            else if (pick < 88)
                add_item(CMD_UNUSED, 8'($urandom_range(255)), 10'($urandom_range(1023)));
            else if (pick < 91)
            begin
                // Fill the buffer without a tail so the partial frame overflows
                for (int i = 0; i < BUFFER_BYTES; i++)
                    add_item(sfs_pkg::CMD_BYTE, non_tail_byte(), 10'($urandom_range(1023)));
            end
            else if (pick < 94)
                add_frame(pick_func(), BUFFER_BYTES - 4 - sfs_pkg::TRAILER, FLAW_NONE,
                          tail_levels(), 8'h00);
            else
                add_frame(pick_func(), $urandom_range(5, 12), FLAW_NONE,
                          tail_levels(), 8'h00);
        end
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            sfs_pkg::CFG_SLAVE_ADDRESS: m_addr = val;
            sfs_pkg::CFG_HEADER_FIRST:  m_hdr1 = val;
            sfs_pkg::CFG_HEADER_SECOND: m_hdr2 = val;
            sfs_pkg::CFG_TAIL_BYTE:     m_tail = val;
            sfs_pkg::CFG_READ_CODE:     m_read = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [7:0] addr, logic [7:0] h1, logic [7:0] h2,
                             logic [7:0] tail, logic [7:0] rd);
        write_reg(sfs_pkg::CFG_SLAVE_ADDRESS, addr);
        write_reg(sfs_pkg::CFG_HEADER_FIRST, h1);
        write_reg(sfs_pkg::CFG_HEADER_SECOND, h2);
        write_reg(sfs_pkg::CFG_TAIL_BYTE, tail);
        write_reg(sfs_pkg::CFG_READ_CODE, rd);
        n_settings++;
    endtask

    // Wait for every queued item to be taken and every result to arrive
    task automatic wait_drained();
        while (n_accepted != n_pushed || expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reply with all sensors high, read while busy, unused command,
        // transmit done, receive error, and a light code equal to the tail value
        add_frame(m_read, 1, FLAW_NONE, ALL_LEVELS, 8'hFF);
        add_frame(m_read, 1, FLAW_NONE, 10'h000, 8'h00);
        add_item(CMD_UNUSED, 8'hFF, ALL_LEVELS);
        add_item(sfs_pkg::CMD_TX_DONE, 8'h00, 10'h000);
        add_item(sfs_pkg::CMD_RX_ERROR, 8'hFF, ALL_LEVELS);
        add_frame(m_tail, 1, FLAW_NONE, 10'h000, 8'h01);
        wait_drained();

        write_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_random_phase(PHASE_ITEMS);
        wait_drained();

        write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_random_phase(PHASE_ITEMS);
        wait_drained();

        write_all(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        add_random_phase(PHASE_ITEMS);
        wait_drained();

        write_all(8'd1, 8'd170, 8'd85, 8'd13, 8'd1);
        add_random_phase(PHASE_ITEMS);
        wait_drained();

        $display("run covered %0d items in %0d frames over %0d register settings",
                 n_accepted, n_frames, n_settings);
        $display("checked %0d reply bytes and %0d light commands",
                 n_reply_bytes, n_lights);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Sender: offer queued items in bursts with random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_item(drv_item);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (item_q.size() > 0)
                begin
                    drv_item = item_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, drv_item.levels, drv_item.data};
                    s_axis_tuser  <= drv_item.cmd;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a changing pattern, with one long hold-off
    int  rx_tick = 0;
    int  rx_mode = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            rx_tick++;
            if (rx_tick % 48 == 0)
                rx_mode = $urandom_range(2);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 30 && item_q.size() > 20)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(1));
                    default: m_axis_tready <= (rx_tick % 4 == 0);
                endcase
            end
        end
    end

    // Compare each output item with the oldest expectation
    always @(posedge clk)
    begin
        slave_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: kind %0d tx_byte 0x%02h light_command 0x%02h",
                       m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
                fail_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.kind == KIND_REPLY)
                    n_reply_bytes++;
                else
                    n_lights++;
                if (m_axis_tuser !== e.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", e.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[7:0] !== e.tx_byte)
                begin
                    $error("tx_byte: expected 0x%02h, got 0x%02h", e.tx_byte,
                           m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("tx_last: expected %0d, got %0d", e.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tdata[15:8] !== e.light)
                begin
                    $error("light_command: expected 0x%02h, got 0x%02h", e.light,
                           m_axis_tdata[15:8]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_crc_unit.sv
hw/rtl/serial_frame_slave_crc16.sv
bench/tb_serial_frame_slave_crc16.sv
